>>> hdl/linear_gradient_pixel_generator_top_defines.svh
// assertion macros shared by the gradient generator modules
// depends on a clock named clock and a reset named reset in the using module
`ifndef LINEAR_GRADIENT_PIXEL_GENERATOR_TOP_DEFINES_SVH
`define LINEAR_GRADIENT_PIXEL_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication
`define LGP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LGP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/lgp_pkg.sv
// shared types, codes and helpers of the linear gradient generator
// no dependencies
package lgp_pkg;

   localparam int COLOR_W   = 24;
   localparam int CHAN_W    = 8;
   localparam int DIM_REG_W = 13;
   localparam int POS_W     = 12;
   localparam int CSR_IDX_W = 3;

   localparam logic VERTICAL = 1'b1;

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_START_COLOR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_COLOR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTICAL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT      = 3'd4;

   // color channel codes, also the order in which steps are divided
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_EMIT
   } lgp_state_type;

   typedef struct packed {
      logic       div_start;
      logic       frame_init;
      logic       load_step;
      logic       emit;
      logic [1:0] chan_idx;
   } lgp_ctl_type;

   function automatic logic [CHAN_W-1:0] chan_of(input logic [COLOR_W-1:0] color,
                                                 input logic [1:0] idx);
      logic [CHAN_W-1:0] c;
      unique case (idx)
         CH_RED:   c = color[23:16];
         CH_GREEN: c = color[15:8];
         CH_BLUE:  c = color[7:0];
         default:  c = '0;
      endcase
      return c;
   endfunction

endpackage

>>> hdl/lgp_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on the assertion macro header
`include "linear_gradient_pixel_generator_top_defines.svh"

module lgp_div #(
   parameter int DIVD_W = 24,
   parameter int DIVS_W = 13
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic              busy,
   output logic              done,
   output logic [DIVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVS_W-1:0] rem_ff, rem_in;
   logic [DIVD_W-1:0] quo_ff, quo_in;
   logic [DIVS_W-1:0] dsr_ff, dsr_in;
   logic [DIVS_W:0]   shifted;
   logic [DIVS_W+1:0] trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIVD_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVD_W);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[DIVS_W+1]) begin
            rem_in = trial[DIVS_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVS_W-1:0];
            quo_in = {quo_ff[DIVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

   `LGP_ASSERT_NOW(a_div_start_idle, start, !busy_ff, "divider started while busy")
   `LGP_ASSERT_NEXT(a_div_done_pulse, done_ff, !done_ff && !busy_ff, "divider done not a pulse")

endmodule

>>> hdl/lgp_ctrl.sv
// sequencer: per-item control and frame-start step division
// depends on lgp_pkg and the assertion macro header
`include "linear_gradient_pixel_generator_top_defines.svh"

module lgp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_restart,
   input  logic                 in_frame,
   input  logic                 out_free,
   input  logic                 div_done,
   output logic                 req_stall,
   output lgp_pkg::lgp_ctl_type ctl
);

   lgp_pkg::lgp_state_type state_ff, state_in;
   logic [1:0]             chan_ff, chan_in;
   logic                   accept;
   logic                   new_frame;

   assign accept    = req_valid && !req_stall;
   assign new_frame = req_restart || !in_frame;

   // next state
   always_comb begin
      state_in = state_ff;
      chan_in  = chan_ff;
      unique case (state_ff)
         lgp_pkg::ST_IDLE: begin
            if (accept && new_frame) begin
               state_in = lgp_pkg::ST_LOAD;
               chan_in  = lgp_pkg::CH_RED;
            end
         end
         lgp_pkg::ST_LOAD: begin
            state_in = lgp_pkg::ST_DIV;
         end
         lgp_pkg::ST_DIV: begin
            if (div_done) begin
               if (chan_ff == lgp_pkg::CH_BLUE) begin
                  state_in = lgp_pkg::ST_EMIT;
               end else begin
                  state_in = lgp_pkg::ST_LOAD;
                  chan_in  = chan_ff + 2'd1;
               end
            end
         end
         lgp_pkg::ST_EMIT: begin
            if (out_free) begin
               state_in = lgp_pkg::ST_IDLE;
            end
         end
         default: state_in = lgp_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall      = 1'b1;
      ctl.div_start  = 1'b0;
      ctl.frame_init = 1'b0;
      ctl.load_step  = 1'b0;
      ctl.emit       = 1'b0;
      ctl.chan_idx   = chan_ff;
      unique case (state_ff)
         lgp_pkg::ST_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               if (new_frame) begin
                  ctl.frame_init = 1'b1;
               end else begin
                  ctl.emit = 1'b1;
               end
            end
         end
         lgp_pkg::ST_LOAD: ctl.div_start = 1'b1;
         lgp_pkg::ST_DIV:  ctl.load_step = div_done;
         lgp_pkg::ST_EMIT: ctl.emit      = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lgp_pkg::ST_IDLE;
         chan_ff  <= lgp_pkg::CH_RED;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

   `LGP_ASSERT_NOW(a_done_in_div, div_done, state_ff == lgp_pkg::ST_DIV, "divider done outside division")

endmodule

>>> hdl/linear_gradient_pixel_generator_top.sv
// linear gradient pixel generator, top level with color and position datapath
// depends on lgp_pkg, lgp_ctrl, lgp_div and the assertion macro header
//
// usage
//  - req channel: one item per pixel; req_restart high starts a new frame at
//    the first pixel, low continues; the first item after reset or after the
//    last pixel of a frame starts a frame as well
//  - rsp channel: one item per request with position, 8-bit red, green and
//    blue channels, and frame_last on the final pixel of the frame
//  - csr channel: always ready; write registers only while no request is in
//    flight; colors take effect at the next frame start
//  - a pixel inside a frame is registered in the cycle after it is accepted and
//    the block takes one item per cycle while the output is drained
//  - an item that starts a frame runs the three channel steps (red, green,
//    blue) through one shared bit-serial divider, each channel through a
//    load state and a division state, and then the result through the emit
//    state; req_stall stays high meanwhile
//  - when rsp_stall is high the result holds in the output register and
//    req_stall rises until it is taken
//  - reset is synchronous; it clears the configuration, control and valid
//    registers to defaults and ends any frame; the next item starts a fresh one
`include "linear_gradient_pixel_generator_top_defines.svh"

module linear_gradient_pixel_generator_top #(
   parameter int MAX_DIM   = 4096,
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_restart,
   // result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lgp_pkg::POS_W-1:0]       rsp_pos_x,
   output logic [lgp_pkg::POS_W-1:0]       rsp_pos_y,
   output logic [lgp_pkg::CHAN_W-1:0]      rsp_red_out,
   output logic [lgp_pkg::CHAN_W-1:0]      rsp_green_out,
   output logic [lgp_pkg::CHAN_W-1:0]      rsp_blue_out,
   output logic                            rsp_frame_last,
   // configuration channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lgp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lgp_pkg::COLOR_W-1:0]     csr_wdata
);

   // dimensions and counters hold up to MAX_DIM
   localparam int DIM_W = $clog2(MAX_DIM + 1);
   // signed Q8.FRAC accumulator and step
   localparam int ACC_W = 9 + FRAC_BITS;
   // step magnitude before the sign is applied
   localparam int QUO_W = 8 + FRAC_BITS;

   localparam logic signed [ACC_W-1:0] ACC_HI = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_LO = {1'b1, {(ACC_W-1){1'b0}}};

   // zero reads as one, anything above MAX_DIM as MAX_DIM
   function automatic logic [DIM_W-1:0] dim_of(input logic [lgp_pkg::DIM_REG_W-1:0] r);
      logic [31:0] v;
      v = 32'(r);
      if (v == 32'd0) begin
         v = 32'd1;
      end else if (v > 32'(MAX_DIM)) begin
         v = 32'(MAX_DIM);
      end
      return v[DIM_W-1:0];
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                       input logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0]   s;
      logic signed [ACC_W-1:0] r;
      s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
      if (s[ACC_W] != s[ACC_W-1]) begin
         r = s[ACC_W] ? ACC_LO : ACC_HI;
      end else begin
         r = s[ACC_W-1:0];
      end
      return r;
   endfunction

   // nonnegative values are below 256.0, so the integer part needs no clamp
   function automatic logic [lgp_pkg::CHAN_W-1:0] to_pixel(input logic signed [ACC_W-1:0] a);
      return a[ACC_W-1] ? '0 : a[ACC_W-2:FRAC_BITS];
   endfunction

   // configuration registers
   logic [lgp_pkg::COLOR_W-1:0]   start_color_ff;
   logic [lgp_pkg::COLOR_W-1:0]   end_color_ff;
   logic                          vertical_ff;
   logic [lgp_pkg::DIM_REG_W-1:0] width_ff;
   logic [lgp_pkg::DIM_REG_W-1:0] height_ff;

   // frame state
   logic                          in_frame_ff, in_frame_in;
   logic [DIM_W-1:0]              inner_ff, inner_in;
   logic [DIM_W-1:0]              outer_ff, outer_in;
   logic signed [ACC_W-1:0]       acc_ff  [3];
   logic signed [ACC_W-1:0]       acc_in  [3];
   logic signed [ACC_W-1:0]       step_ff [3];

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [lgp_pkg::POS_W-1:0]     pos_x_ff, pos_y_ff;
   logic [lgp_pkg::CHAN_W-1:0]    red_ff, green_ff, blue_ff;
   logic                          last_ff;

   lgp_pkg::lgp_ctl_type          ctl;
   logic                          out_free;
   logic                          vert;
   logic [DIM_W-1:0]              inner_len, outer_len;
   logic [DIM_W-1:0]              inner_inc, outer_inc;
   logic                          emit_last;
   logic [31:0]                   px_wide, py_wide;

   // division operands for the channel under work
   logic [lgp_pkg::CHAN_W-1:0]    ch_start, ch_end, ch_mag;
   logic                          ch_neg;
   logic [QUO_W-1:0]              quotient;
   logic                          div_done, div_busy;
   logic signed [ACC_W-1:0]       new_step;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_color_ff <= '0;
         end_color_ff   <= '0;
         vertical_ff    <= 1'b0;
         width_ff       <= lgp_pkg::DIM_REG_W'(1);
         height_ff      <= lgp_pkg::DIM_REG_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lgp_pkg::CSR_START_COLOR: start_color_ff <= csr_wdata;
            lgp_pkg::CSR_END_COLOR:   end_color_ff   <= csr_wdata;
            lgp_pkg::CSR_VERTICAL:    vertical_ff    <= csr_wdata[0];
            lgp_pkg::CSR_WIDTH:       width_ff       <= csr_wdata[lgp_pkg::DIM_REG_W-1:0];
            lgp_pkg::CSR_HEIGHT:      height_ff      <= csr_wdata[lgp_pkg::DIM_REG_W-1:0];
            default: ;
         endcase
      end
   end

   lgp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .in_frame    (in_frame_ff),
      .out_free    (out_free),
      .div_done    (div_done),
      .req_stall   (req_stall),
      .ctl         (ctl)
   );

   // |end - start| of the channel, scaled to fixed point, over the outer length
   always_comb begin
      ch_start = lgp_pkg::chan_of(start_color_ff, ctl.chan_idx);
      ch_end   = lgp_pkg::chan_of(end_color_ff, ctl.chan_idx);
      ch_neg   = ch_end < ch_start;
      ch_mag   = ch_neg ? (ch_start - ch_end) : (ch_end - ch_start);
      new_step = ch_neg ? -$signed({1'b0, quotient}) : $signed({1'b0, quotient});
   end

   lgp_div #(
      .DIVD_W (QUO_W),
      .DIVS_W (DIM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_start),
      .dividend ({ch_mag, {FRAC_BITS{1'b0}}}),
      .divisor  (outer_len),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      vert      = vertical_ff == lgp_pkg::VERTICAL;
      inner_len = vert ? dim_of(width_ff) : dim_of(height_ff);
      outer_len = vert ? dim_of(height_ff) : dim_of(width_ff);
      inner_inc = inner_ff + 1'b1;
      outer_inc = outer_ff + 1'b1;
      px_wide   = 32'(vert ? inner_ff : outer_ff);
      py_wide   = 32'(vert ? outer_ff : inner_ff);
   end

   // frame start seeds counters and accumulators; a pixel advances them
   always_comb begin
      in_frame_in = in_frame_ff;
      inner_in    = inner_ff;
      outer_in    = outer_ff;
      emit_last   = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc_in[i] = acc_ff[i];
      end
      if (ctl.frame_init) begin
         in_frame_in = 1'b1;
         inner_in    = '0;
         outer_in    = '0;
         for (int i = 0; i < 3; i++) begin
            acc_in[i] = $signed({1'b0, lgp_pkg::chan_of(start_color_ff, 2'(i)),
                                 {FRAC_BITS{1'b0}}});
         end
      end else if (ctl.emit) begin
         if (inner_inc >= inner_len) begin
            // end of line: color advances one step
            inner_in = '0;
            for (int i = 0; i < 3; i++) begin
               acc_in[i] = sat_add(acc_ff[i], step_ff[i]);
            end
            if (outer_inc >= outer_len) begin
               outer_in    = '0;
               in_frame_in = 1'b0;
               emit_last   = 1'b1;
            end else begin
               outer_in = outer_inc;
            end
         end else begin
            inner_in = inner_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
      end
   end

   always_ff @(posedge clock) begin
      inner_ff <= inner_in;
      outer_ff <= outer_in;
      for (int i = 0; i < 3; i++) begin
         acc_ff[i] <= acc_in[i];
      end
      if (ctl.load_step) begin
         step_ff[ctl.chan_idx] <= new_step;
      end
   end

   // output register, refilled while it drains
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         pos_x_ff <= px_wide[lgp_pkg::POS_W-1:0];
         pos_y_ff <= py_wide[lgp_pkg::POS_W-1:0];
         red_ff   <= to_pixel(acc_ff[lgp_pkg::CH_RED]);
         green_ff <= to_pixel(acc_ff[lgp_pkg::CH_GREEN]);
         blue_ff  <= to_pixel(acc_ff[lgp_pkg::CH_BLUE]);
         last_ff  <= emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pos_x      = pos_x_ff;
   assign rsp_pos_y      = pos_y_ff;
   assign rsp_red_out    = red_ff;
   assign rsp_green_out  = green_ff;
   assign rsp_blue_out   = blue_ff;
   assign rsp_frame_last = last_ff;

   `LGP_ASSERT_NEXT(a_last_ends_frame, ctl.emit && emit_last, !in_frame_ff && rsp_frame_last, "last pixel did not close the frame")
   `LGP_ASSERT_NEXT(a_init_opens_frame, ctl.frame_init, in_frame_ff && req_stall, "frame start did not open the frame")
   `LGP_ASSERT_NOW(a_busy_stalls, div_busy, req_stall && !ctl.emit, "item taken during step division")

endmodule
